FILE: sv/mdpad_pkg.sv
// Package: shared types, constants and helpers for the message padding block.
`timescale 1ns / 1ps
`default_nettype none
package mdpad_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    localparam int COUNT_W = 61;
    localparam int SLOT_W  = 4;

    localparam logic [7:0]        PAD_BYTE      = 8'h80;
    localparam logic [SLOT_W-1:0] SLOT_LEN_HI   = 4'd14;
    localparam logic [SLOT_W-1:0] SLOT_LAST     = 4'd15;
    localparam logic [5:0]        LAST_BYTE_POS = 6'd63;
    localparam logic [1:0]        LAST_LANE     = 2'd3;

    typedef enum logic {
        K_DATA = 1'b0,
        K_END  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_ZERO,
        BK_LEN_HI,
        BK_LEN_LO
    } t_back_state;

    function automatic logic [31:0] byte_swap(input logic [31:0] w);
        byte_swap = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage
`default_nettype wire

FILE: sv/mdpad_front.sv
// Front end: accepts input requests and classifies them into queue entries.
`timescale 1ns / 1ps
`default_nettype none
module mdpad_front (
    input  wire logic                   i_in_valid,
    input  wire logic                   i_action,
    input  wire logic [7:0]             i_data_byte,
    input  wire mdpad_pkg::t_queue_status i_q_status,
    output logic                        o_in_stall,
    output logic                        o_push,
    output mdpad_pkg::t_entry           o_entry
);

    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    // drop the byte on an end request
    always_comb begin
        o_entry.kind = i_action ? mdpad_pkg::K_END : mdpad_pkg::K_DATA;
        o_entry.data = i_action ? 8'h00 : i_data_byte;
    end

endmodule
`default_nettype wire

FILE: sv/mdpad_queue.sv
// Two-entry queue between the front end and the padding engine.
`timescale 1ns / 1ps
`default_nettype none
module mdpad_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire mdpad_pkg::t_entry      i_entry,
    input  wire logic                   i_pop,
    output mdpad_pkg::t_entry           o_head,
    output mdpad_pkg::t_queue_status    o_status
);

    mdpad_pkg::t_entry                r_mem [mdpad_pkg::QUEUE_DEPTH];
    logic [mdpad_pkg::QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [mdpad_pkg::QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [mdpad_pkg::QUEUE_CW-1:0]   r_count, n_count;
    logic                             do_push, do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == mdpad_pkg::QUEUE_CW'(mdpad_pkg::QUEUE_DEPTH));
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        do_push  = i_push && !o_status.full;
        do_pop   = i_pop && !o_status.empty;
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + mdpad_pkg::QUEUE_CW'(do_push) - mdpad_pkg::QUEUE_CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

FILE: sv/mdpad_back.sv
// Padding engine: packs bytes into words and sequences the padding run.
`timescale 1ns / 1ps
`default_nettype none
module mdpad_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_len_be,
    input  wire mdpad_pkg::t_entry      i_head,
    input  wire mdpad_pkg::t_queue_status i_q_status,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [31:0]                 o_padded_word,
    output logic                        o_block_end,
    output logic                        o_message_end
);

    mdpad_pkg::t_back_state             r_state, n_state;
    logic [mdpad_pkg::COUNT_W-1:0]      r_cnt, n_cnt;
    logic [31:0]                        r_part, n_part;
    logic [mdpad_pkg::SLOT_W-1:0]       r_slot, n_slot;
    logic                               r_out_valid, n_out_valid;
    logic [31:0]                        r_word, n_word;
    logic                               r_blk, n_blk;
    logic                               r_msg, n_msg;

    logic                               out_free;
    logic [1:0]                         lane;
    logic [mdpad_pkg::SLOT_W-1:0]       cur_slot;
    logic [63:0]                        bitlen;
    logic [31:0]                        lane_word;

    assign out_free = !r_out_valid || !i_out_stall;
    assign lane     = r_cnt[1:0];
    assign cur_slot = r_cnt[5:2];
    assign bitlen   = {r_cnt, 3'b000};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_part      = r_part;
        n_slot      = r_slot;
        n_out_valid = r_out_valid && i_out_stall;
        n_word      = r_word;
        n_blk       = r_blk;
        n_msg       = r_msg;
        o_pop       = 1'b0;
        lane_word   = '0;

        unique case (r_state)
            mdpad_pkg::BK_RUN: begin
                if (!i_q_status.empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_head.kind == mdpad_pkg::K_DATA) begin
                        lane_word = {24'b0, i_head.data} << {lane, 3'b000};
                        n_cnt     = r_cnt + mdpad_pkg::COUNT_W'(1);
                        if (lane == mdpad_pkg::LAST_LANE) begin
                            n_out_valid = 1'b1;
                            n_word      = r_part | lane_word;
                            n_blk       = (r_cnt[5:0] == mdpad_pkg::LAST_BYTE_POS);
                            n_msg       = 1'b0;
                            n_part      = '0;
                        end else begin
                            n_part = r_part | lane_word;
                        end
                    end else begin
                        lane_word   = {24'b0, mdpad_pkg::PAD_BYTE} << {lane, 3'b000};
                        n_out_valid = 1'b1;
                        n_word      = r_part | lane_word;
                        n_blk       = (cur_slot == mdpad_pkg::SLOT_LAST);
                        n_msg       = 1'b0;
                        n_part      = '0;
                        n_slot      = cur_slot + mdpad_pkg::SLOT_W'(1);
                        n_state     = (cur_slot + mdpad_pkg::SLOT_W'(1)
                                       == mdpad_pkg::SLOT_LEN_HI)
                                      ? mdpad_pkg::BK_LEN_HI : mdpad_pkg::BK_ZERO;
                    end
                end
            end
            mdpad_pkg::BK_ZERO: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_word      = '0;
                    n_blk       = (r_slot == mdpad_pkg::SLOT_LAST);
                    n_msg       = 1'b0;
                    n_slot      = r_slot + mdpad_pkg::SLOT_W'(1);
                    if (r_slot + mdpad_pkg::SLOT_W'(1) == mdpad_pkg::SLOT_LEN_HI) begin
                        n_state = mdpad_pkg::BK_LEN_HI;
                    end
                end
            end
            mdpad_pkg::BK_LEN_HI: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_word      = i_len_be ? mdpad_pkg::byte_swap(bitlen[63:32])
                                           : bitlen[31:0];
                    n_blk       = 1'b0;
                    n_msg       = 1'b0;
                    n_state     = mdpad_pkg::BK_LEN_LO;
                end
            end
            mdpad_pkg::BK_LEN_LO: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_word      = i_len_be ? mdpad_pkg::byte_swap(bitlen[31:0])
                                           : bitlen[63:32];
                    n_blk       = 1'b1;
                    n_msg       = 1'b1;
                    n_cnt       = '0;
                    n_slot      = '0;
                    n_state     = mdpad_pkg::BK_RUN;
                end
            end
            default: begin
                n_state = mdpad_pkg::BK_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mdpad_pkg::BK_RUN;
            r_cnt       <= '0;
            r_part      <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_part      <= n_part;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_blk  <= n_blk;
        r_msg  <= n_msg;
    end

    assign o_out_valid   = r_out_valid;
    assign o_padded_word = r_word;
    assign o_block_end   = r_blk;
    assign o_message_end = r_msg;

endmodule
`default_nettype wire

FILE: sv/md_message_padding.sv
// Top level: Merkle-Damgard message padding, bytes in, padded 32-bit words out.
//
// Input channel: one request per accepted edge (i_in_valid high, o_in_stall
// low). i_action = 0 carries a message byte in i_data_byte; i_action = 1 ends
// the message and starts the padding run (the byte is ignored).
// Output channel: padded words, earliest byte in bits 7:0, accepted when
// o_out_valid is high and i_out_stall is low. o_block_end marks the last word
// of each 64-byte block; o_message_end marks the final word of the message.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the length byte order
// bit (1 = big-endian length, 0 = little-endian). Write it only while idle.
//
// Timing: a request is written into the two-entry queue at the edge that
// accepts it; when the engine takes the entry it loads the output register,
// so each word passes through the queue and then the output register.
// Data bytes sustain one per cycle while the output is not stalled. An end
// request occupies the engine while it emits the pad word, the zero fill and two
// length words; during that run the queue fills and o_in_stall rises.
// A stalled output word is held; the engine then waits and the queue backs up.
// Reset (synchronous, active low) empties the queue, clears the byte count,
// the partial word and the output valid, and selects little-endian length.
`timescale 1ns / 1ps
`default_nettype none
module md_message_padding (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_padded_word,
    output logic             o_block_end,
    output logic             o_message_end
);

    // Length byte order register.
    logic r_len_be;

    mdpad_pkg::t_entry        front_entry;
    mdpad_pkg::t_entry        q_head;
    mdpad_pkg::t_queue_status q_status;
    logic                     push;
    logic                     pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_be <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_len_be <= i_cfg_wr_data;
        end
    end

    // Classify incoming requests; stall only on a full queue.
    mdpad_front u_front (
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .i_q_status  (q_status),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_entry     (front_entry)
    );

    // Decouple the input side from the padding run.
    mdpad_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // Pack bytes, run the zero fill and append the bit length.
    mdpad_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_len_be      (r_len_be),
        .i_head        (q_head),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_padded_word (o_padded_word),
        .o_block_end   (o_block_end),
        .o_message_end (o_message_end)
    );

endmodule
`default_nettype wire

FILE: sv/mdpad_checker.sv
// Port-level checker for the message padding block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mdpad_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_padded_word,
    input wire logic        o_block_end,
    input wire logic        o_message_end
);

    // The final word always closes a block.
    a_end_closes_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_message_end |-> o_block_end)
        else $error("message end without block end");

    // A stalled word is held.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_padded_word)
            && $stable(o_message_end))
        else $error("stalled output word changed");

    // Reset leaves nothing to deliver.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Reset leaves the queue empty and ready.
    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind md_message_padding mdpad_checker u_mdpad_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_padded_word (o_padded_word),
    .o_block_end   (o_block_end),
    .o_message_end (o_message_end)
);
`default_nettype wire

FILE: tb/tb_md_message_padding.sv
// Testbench for md_message_padding: directed table, then random messages checked by a predictor.
`timescale 1ns / 1ps
module tb_md_message_padding;

    // Cycles to let pass after the last expected word before touching the
    // register or ending the run.
    localparam int SETTLE_CYCLES = 6;
    // Cycles in a row with no request and no word accepted before giving up.
    localparam int STUCK_LIMIT   = 2000;
    // Number of mismatches printed in full; later ones are only counted.
    localparam int REPORT_LIMIT  = 10;
    // Random requests per random phase.
    localparam int PHASE_BUDGET  = 86;

    // One padded word as it leaves the block.
    typedef struct packed {
        logic [31:0] word;
        logic        blk_end;
        logic        msg_end;
    } padded_t;

    // One row of directed stimulus. Where typed is set, the row completes
    // exactly one word and that word is written out by hand.
    typedef struct packed {
        mdpad_pkg::t_kind kind;
        logic [7:0]       data;
        logic             typed;
        logic [31:0]      word;
        logic             blk_end;
        logic             msg_end;
    } stim_row_t;

    localparam int DIRECTED_COUNT = 23;
    localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        // Extremes after reset: alternate all-zero and all-one bytes.
        '{mdpad_pkg::K_DATA, 8'h00, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_DATA, 8'hFF, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_DATA, 8'h00, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_DATA, 8'hFF, 1'b1, 32'hFF00_FF00, 1'b0, 1'b0},
        // End of message on a word boundary, with a nonzero byte to ignore.
        '{mdpad_pkg::K_END,  8'hA5, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        // Empty message right after the previous one closed.
        '{mdpad_pkg::K_END,  8'h00, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        // Memory byte order: earliest byte lands in bits 7:0.
        '{mdpad_pkg::K_DATA, 8'h01, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_DATA, 8'h02, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_DATA, 8'h03, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_DATA, 8'h04, 1'b1, 32'h0403_0201, 1'b0, 1'b0},
        // Lone high bit, lone low bit, and their complements.
        '{mdpad_pkg::K_DATA, 8'h80, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_DATA, 8'h7F, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_DATA, 8'h01, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_DATA, 8'hFE, 1'b1, 32'hFE01_7F80, 1'b0, 1'b0},
        // End in the middle of a word (one byte, one byte again, then three bytes gathered).
        '{mdpad_pkg::K_DATA, 8'h55, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_END,  8'hFF, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_DATA, 8'hAA, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_END,  8'h00, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_DATA, 8'h12, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_DATA, 8'h34, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_DATA, 8'h56, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        '{mdpad_pkg::K_END,  8'h5A, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
        // Back-to-back end: another empty message.
        '{mdpad_pkg::K_END,  8'hFF, 1'b0, 32'h0000_0000, 1'b0, 1'b0}
    };

    // Every block input starts at a known value.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        i_action      = 1'b0;
    logic [7:0]  i_data_byte   = 8'h00;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_padded_word;
    logic        o_block_end;
    logic        o_message_end;

    md_message_padding uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_padded_word (o_padded_word),
        .o_block_end   (o_block_end),
        .o_message_end (o_message_end)
    );

    // 20 ns period: 10 ns high, 10 ns low.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Idle rates in percent, switched between phases.
    int send_idle_pct  = 17;
    int recv_stall_pct = 68;

    // Predictor state: own copy of the byte count, the word being gathered
    // and the length byte order.
    logic [mdpad_pkg::COUNT_W-1:0] msg_bytes      = '0;
    logic [31:0]                   gather_word    = '0;
    logic                          len_big_endian = 1'b0;

    // Words caused by the request just accepted, and all words still owed.
    padded_t step_words [$];
    padded_t pending_words [$];

    int mismatches = 0;
    int stuck_cycles = 0;

    // Place one byte in the padded stream; close a word on every fourth.
    task automatic take_byte(input logic [7:0] b);
        gather_word[8*msg_bytes[1:0] +: 8] = b;
        msg_bytes = msg_bytes + 61'd1;
        if (msg_bytes[1:0] == 2'd0) begin
            step_words.push_back('{gather_word, (msg_bytes[5:0] == 6'd0), 1'b0});
            gather_word = '0;
        end
    endtask

    // Work out every word one accepted request causes.
    task automatic predict_request(input mdpad_pkg::t_kind kind, input logic [7:0] data);
        logic [63:0] bit_len;
        padded_t     closing;
        int          i;
        step_words.delete();
        if (kind == mdpad_pkg::K_DATA) begin
            take_byte(data);
        end else begin
            // Length is taken before padding; wraps with the 61-bit count.
            bit_len = {msg_bytes, 3'b000};
            take_byte(mdpad_pkg::PAD_BYTE);
            while (msg_bytes[5:0] != 6'd56) begin
                take_byte(8'h00);
            end
            for (i = 0; i < 8; i++) begin
                if (len_big_endian) begin
                    take_byte(bit_len[8*(7-i) +: 8]);
                end else begin
                    take_byte(bit_len[8*i +: 8]);
                end
            end
            // Flag the last word of the padded message.
            closing = step_words.pop_back();
            closing.msg_end = 1'b1;
            step_words.push_back(closing);
            msg_bytes   = '0;
            gather_word = '0;
        end
    endtask

    // Offer one request, idling first at the current rate, and hold it
    // until accepted. Valid is left high on return; the next call or
    // wait_words_drained sets it at the following falling edge.
    task automatic send_item(input stim_row_t row);
        bit taken;
        taken = 1'b0;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= row.kind;
        i_data_byte <= row.data;
        while (!taken) begin
            @(posedge i_clk);
            if (!o_in_stall) begin
                taken = 1'b1;
            end else begin
                @(negedge i_clk);
            end
        end
        // Advance the predictor always; swap in the hand-written word if any.
        predict_request(row.kind, row.data);
        if (row.typed) begin
            step_words.delete();
            step_words.push_back('{row.word, row.blk_end, row.msg_end});
        end
        foreach (step_words[k]) begin
            pending_words.push_back(step_words[k]);
        end
    endtask

    // Drop valid, wait until every owed word has come, then let the block settle.
    task automatic wait_words_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the length byte order while the block is idle.
    task automatic write_length_order(input logic big_endian);
        wait_words_drained();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= big_endian;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        len_big_endian = big_endian;
    endtask

    // One well-formed message: len random bytes, then an end request
    // carrying a random byte that must be ignored.
    task automatic send_message(input int len);
        stim_row_t row;
        int        i;
        row = '0;
        for (i = 0; i < len; i++) begin
            row.kind = mdpad_pkg::K_DATA;
            row.data = 8'($urandom_range(0, 255));
            send_item(row);
        end
        row.kind = mdpad_pkg::K_END;
        row.data = 8'($urandom_range(0, 255));
        send_item(row);
    endtask

    // Random messages until the budget is spent. Lengths lean short, with
    // a good share near the 56-byte boundary, so the padding often spills into a
    // second block, and some around one full block so block ends fall mid-message.
    task automatic run_random_phase(input int budget, input bit pause_first);
        int sent;
        int len;
        int pick;
        bit pause_now;
        sent      = 0;
        pause_now = pause_first;
        while (sent < budget) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                len = $urandom_range(0, 12);
            end else if (pick < 8) begin
                len = $urandom_range(52, 60);
            end else if (pick == 8) begin
                len = $urandom_range(61, 72);
            end else begin
                len = 0;
            end
            send_message(len);
            sent += len + 1;
            // Hold the sender off now and then until every word has come.
            if (pause_now || ($urandom_range(0, 4) == 0)) begin
                wait_words_drained();
            end
            pause_now = 1'b0;
        end
    endtask

    // Receiver: stall at the current rate, decided at each falling edge.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Checker: compare each accepted word with the oldest owed word.
    padded_t want_word;
    padded_t got_word;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_word = '{o_padded_word, o_block_end, o_message_end};
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected word %h block_end %b message_end %b",
                             got_word.word, got_word.blk_end, got_word.msg_end);
                end
            end else begin
                want_word = pending_words.pop_front();
                if (got_word !== want_word) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("word mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 want_word.word, want_word.blk_end, want_word.msg_end,
                                 got_word.word, got_word.blk_end, got_word.msg_end);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with nothing accepted on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("[md_message_padding] ERROR");
            $finish;
        end
    end

    initial begin
        int r;
        // Hold reset, then release it at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at the reset byte order (little-endian); the
        // sender idles lightly, the receiver stalls often.
        send_idle_pct  = 17;
        recv_stall_pct = 68;
        for (r = 0; r < DIRECTED_COUNT; r++) begin
            send_item(DIRECTED_ROWS[r]);
        end

        // Random, big-endian length; force one full drain pause early.
        write_length_order(1'b1);
        run_random_phase(PHASE_BUDGET, 1'b1);

        // Random, little-endian length, idle rates swapped.
        wait_words_drained();
        send_idle_pct  = 68;
        recv_stall_pct = 17;
        write_length_order(1'b0);
        run_random_phase(PHASE_BUDGET, 1'b0);

        // Random, big-endian again, full rate on both sides.
        wait_words_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_length_order(1'b1);
        run_random_phase(PHASE_BUDGET, 1'b0);

        // Drain, settle, and catch any stray word in the tail.
        wait_words_drained();
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("[md_message_padding] OK");
        end else begin
            $display("[md_message_padding] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/mdpad_pkg.sv
sv/mdpad_front.sv
sv/mdpad_queue.sv
sv/mdpad_back.sv
sv/md_message_padding.sv
sv/mdpad_checker.sv
tb/tb_md_message_padding.sv
